// ===== rtl/bat_pkg.sv =====
// Package for the bus access timing model: event and result beat types,
// event codes and burst timing constants. No dependencies.
package bat_pkg;

  // Event codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_FETCH16  = 3'd0,
    ACT_FETCH32  = 3'd1,
    ACT_DATA_NS  = 3'd2,
    ACT_DATA_SEQ = 3'd3,
    ACT_INTERNAL = 3'd4,
    ACT_MARK_SEQ = 3'd5
  } bat_action_e;

  // Data access width codes.
  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;

  // Fetch beats after which a main RAM burst is restarted.
  localparam logic [7:0] BURST_LIMIT = 8'd241;
  localparam logic [7:0] BURST_LEN_MAX = 8'hFF;
  // Burst start offset from which a 32-byte boundary restarts the burst.
  localparam logic [4:0] BOUNDARY_OFFSET = 5'h1A;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] address;
    logic        is_write;
    logic [1:0]  width_code;
    logic [3:0]  region_id;
    logic        region_main_ram;
    logic        region_internal_ram;
    logic [5:0]  wait_nonseq;
    logic [5:0]  wait_seq;
    logic [7:0]  internal_cycles;
  } bat_in_t;

  typedef struct packed {
    logic [8:0] cycles_added;
    logic       fetch_sequential;
  } bat_out_t;

endpackage

// ===== rtl/bat_core.sv =====
// Timing state and per-event cost logic of the bus access timing model.
// Depends on bat_pkg.
module bat_core
  import bat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  bat_in_t  item_i,
  output bat_out_t result_o
);

  // The burst end time is tracked as its lead over the timestamp (at most 5).
  logic [2:0] slack_q, slack_d;
  logic [7:0] burst_len_q, burst_len_d;
  logic [4:0] start_off_q, start_off_d;
  logic       next_seq_q, next_seq_d;
  logic       code_int_q, code_int_d;
  logic [3:0] data_id_q, data_id_d;
  logic       data_main_q, data_main_d;
  logic       data_int_q, data_int_d;
  logic [5:0] data_wns_q, data_wns_d;
  logic [5:0] data_ws_q, data_ws_d;

  logic [8:0] adv;
  logic       boundary;
  logic       do_start, do_beat, do_plain;
  logic [2:0] begin_c, term_c, beat_c;
  logic       fetch_seq, seq_ok, reload;
  logic       eff_main, eff_int;
  logic [5:0] eff_wns, eff_ws;
  logic [8:0] plain_adv;

  assign boundary = (start_off_q >= BOUNDARY_OFFSET) && (item_i.address[4:0] == 5'd0);
  assign reload   = (item_i.address[17:0] == 18'd0);
  assign eff_main = reload ? item_i.region_main_ram : data_main_q;
  assign eff_int  = reload ? item_i.region_internal_ram : data_int_q;
  assign eff_wns  = reload ? item_i.wait_nonseq : data_wns_q;
  assign eff_ws   = reload ? item_i.wait_seq : data_ws_q;

  always_comb begin
    slack_d     = slack_q;
    burst_len_d = burst_len_q;
    start_off_d = start_off_q;
    next_seq_d  = next_seq_q;
    code_int_d  = code_int_q;
    data_id_d   = data_id_q;
    data_main_d = data_main_q;
    data_int_d  = data_int_q;
    data_wns_d  = data_wns_q;
    data_ws_d   = data_ws_q;
    do_start    = 1'b0;
    do_beat     = 1'b0;
    do_plain    = 1'b0;
    begin_c     = 3'd0;
    term_c      = 3'd0;
    beat_c      = 3'd0;
    plain_adv   = 9'd0;
    fetch_seq   = 1'b0;
    seq_ok      = 1'b1;

    case (bat_action_e'(item_i.action))
      ACT_FETCH16, ACT_FETCH32: begin
        code_int_d = item_i.region_internal_ram;
        if (item_i.region_main_ram) begin
          fetch_seq  = next_seq_q && (burst_len_q < BURST_LIMIT) && !boundary;
          next_seq_d = fetch_seq;
          if (fetch_seq) begin
            do_beat = 1'b1;
            beat_c  = (item_i.action == ACT_FETCH32) ? 3'd2 : 3'd1;
            if (burst_len_q != BURST_LEN_MAX) begin
              burst_len_d = burst_len_q + 8'd1;
            end
          end else begin
            do_start = 1'b1;
            begin_c  = (item_i.action == ACT_FETCH32) ? 3'd6 : 3'd5;
            term_c   = 3'd3;
          end
        end else begin
          do_plain  = 1'b1;
          plain_adv = {3'd0, next_seq_q ? item_i.wait_seq : item_i.wait_nonseq};
        end
      end
      ACT_DATA_NS: begin
        data_id_d   = item_i.region_id;
        data_main_d = item_i.region_main_ram;
        data_int_d  = item_i.region_internal_ram;
        data_wns_d  = item_i.wait_nonseq;
        data_ws_d   = item_i.wait_seq;
        next_seq_d  = 1'b0;
        if (item_i.region_main_ram) begin
          do_start = 1'b1;
          if (item_i.is_write) begin
            case (item_i.width_code)
              WIDTH_BYTE: begin begin_c = 3'd4; term_c = 3'd4; end
              WIDTH_HALF: begin begin_c = 3'd3; term_c = 3'd5; end
              default:    begin begin_c = 3'd4; term_c = 3'd5; end
            endcase
          end else begin
            begin_c = item_i.width_code[1] ? 3'd6 : 3'd5;
            term_c  = 3'd3;
          end
        end else begin
          do_plain  = 1'b1;
          plain_adv = {3'd0, item_i.wait_nonseq} +
                      {8'd0, item_i.is_write & item_i.region_internal_ram & code_int_q};
        end
      end
      ACT_DATA_SEQ: begin
        if (reload) begin
          data_id_d   = item_i.region_id;
          data_main_d = item_i.region_main_ram;
          data_int_d  = item_i.region_internal_ram;
          data_wns_d  = item_i.wait_nonseq;
          data_ws_d   = item_i.wait_seq;
          seq_ok      = (item_i.region_id == data_id_q);
        end
        if (eff_main) begin
          if (seq_ok && !(!item_i.is_write && boundary)) begin
            do_beat = 1'b1;
            beat_c  = 3'd2;
          end else begin
            do_start = 1'b1;
            begin_c  = item_i.is_write ? 3'd4 : 3'd6;
            term_c   = item_i.is_write ? 3'd5 : 3'd3;
          end
        end else begin
          do_plain = 1'b1;
          if (seq_ok) begin
            plain_adv = {3'd0, eff_ws};
          end else begin
            plain_adv = {3'd0, eff_wns} +
                        {8'd0, item_i.is_write & eff_int & code_int_q};
          end
        end
      end
      ACT_INTERNAL: begin
        do_plain   = 1'b1;
        plain_adv  = {1'b0, item_i.internal_cycles};
        next_seq_d = 1'b0;
      end
      ACT_MARK_SEQ: begin
        next_seq_d = 1'b1;
      end
      default: begin
      end
    endcase

    // Advance the timestamp and move the burst end lead with it.
    if (do_start) begin
      adv         = {6'd0, slack_q} + {6'd0, begin_c};
      slack_d     = term_c;
      burst_len_d = {5'd0, begin_c};
      start_off_d = item_i.address[4:0];
    end else if (do_beat) begin
      adv = {6'd0, beat_c};
    end else if (do_plain) begin
      adv     = plain_adv;
      slack_d = (plain_adv >= {6'd0, slack_q}) ? 3'd0 : (slack_q - plain_adv[2:0]);
    end else begin
      adv = 9'd0;
    end
  end

  assign result_o.cycles_added     = adv;
  assign result_o.fetch_sequential = next_seq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q     <= '0;
      burst_len_q <= '0;
      start_off_q <= '0;
      next_seq_q  <= 1'b0;
      code_int_q  <= 1'b0;
      data_id_q   <= '0;
      data_main_q <= 1'b0;
      data_int_q  <= 1'b0;
      data_wns_q  <= '0;
      data_ws_q   <= '0;
    end else if (step_i) begin
      slack_q     <= slack_d;
      burst_len_q <= burst_len_d;
      start_off_q <= start_off_d;
      next_seq_q  <= next_seq_d;
      code_int_q  <= code_int_d;
      data_id_q   <= data_id_d;
      data_main_q <= data_main_d;
      data_int_q  <= data_int_d;
      data_wns_q  <= data_wns_d;
      data_ws_q   <= data_ws_d;
    end
  end

endmodule

// ===== rtl/bus_access_timing_model.sv =====
// Top level of the bus access timing model: input beat register, timing core
// and result register. Depends on bat_pkg and bat_core.
//
// The block takes one bus event beat per clock while the output is not
// stalled and returns one result beat per event: the cycles the event adds to
// the running timestamp and whether the next code fetch counts as sequential.
// An event is registered in the input register on acceptance, costed by the
// timing core against the burst and region state, and the result lands in the
// output register; the sustained rate is one event per clock while the output
// does not stall. The core updates its state (burst lead, burst length, cached
// data region) on every step, which sets that rate. The main RAM burst end
// time is held as its lead over the timestamp, which is all the cost of a
// later event depends on. Stall on the output backs up into the input
// register and then onto in_stall_o in the same cycle; a pending result never
// blocks the next event from entering while the output drains.
module bus_access_timing_model
  import bat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bat_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bat_out_t out_data_o
);

  logic     in_vld_q;
  bat_in_t  in_q;
  logic     out_vld_q;
  bat_out_t out_q;
  bat_out_t result;
  logic     step;

  // Cost the held event whenever the result register is free or draining.
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  bat_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (result)
  );

  // Input beat register: load whenever not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register: fill on a step, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
